// File: design/apjs_pkg.sv
// Shared types and constants for the aging priority job scheduler.
// Used by the scheduler top level and its checker; depends on nothing.
package apjs_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned PriW  = 4;
  localparam int unsigned WaitW = 8;
  localparam int unsigned RunW  = 32;

  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdEnqueue = 2'd1;
  localparam logic [1:0] CmdDequeue = 2'd2;
  localparam logic [1:0] CmdList    = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatNotFound = 2'd2;

  localparam logic CfgAging = 1'b0;
  localparam logic CfgCap   = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   job_id;
    logic [IdW-1:0]   owner;
    logic [PriW-1:0]  base_pri;
    logic [PriW-1:0]  cur_pri;
    logic [WaitW-1:0] wait_cnt;
    logic [RunW-1:0]  run_cnt;
  } slot_t;

  typedef struct packed {
    logic             kind;
    logic [IdW-1:0]   job_number;
    logic [IdW-1:0]   job_owner;
    logic [RunW-1:0]  run_ticks;
    logic [WaitW-1:0] wait_ticks;
    logic [PriW-1:0]  job_priority;
    logic             is_running;
    logic [IdW-1:0]   running_job;
    logic             switched;
    logic [1:0]       status;
    logic             last;
  } rec_t;

endpackage

// File: design/apjs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the slot store and the queue link store.
module apjs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/aging_priority_job_scheduler.sv
// Top level of the aging priority job scheduler: tick sequencer and queue control.
// Depends on apjs_pkg and apjs_ram (slot store and link store).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | cmd, base_priority, owner_id, ...
//  out     | output    | out_valid_o/out_stall_i| record_kind ... last, one per word
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A tick walks the N waiting jobs up to three times (aging, dequeue search or listing,
// selection), each walk after a setup state, plus bookkeeping; an enqueue adds a scan
// over up to MAX_JOBS valid bits for a free slot and the link update. A slot update is a read,
// a registered read, and a write back through the slot memory's separate write port.
// A stalled output holds the sequencer in place, and the input stays stalled until the
// tick report is issued. Reset clears the valid bits, the queue and running registers and
// the id counter, and sets the configuration to its defaults (aging 5, cap 3).
module aging_priority_job_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [3:0]               base_priority_i,
  input  logic [15:0]              owner_id_i,
  input  logic [15:0]              target_job_i,
  input  logic                     running_finished_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     record_kind_o,
  output logic [15:0]              job_number_o,
  output logic [15:0]              job_owner_o,
  output logic [31:0]              run_ticks_o,
  output logic [7:0]               wait_ticks_o,
  output logic [3:0]               job_priority_o,
  output logic                     is_running_o,
  output logic [15:0]              running_job_o,
  output logic                     switched_o,
  output logic [1:0]               status_o,
  output logic                     last_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [7:0]               cfg_data_i
);
  import apjs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned SW = $bits(slot_t);

  typedef enum logic [4:0] {
    S_IDLE, S_RUN_RD, S_RUN_WR, S_AGE_INIT, S_AGE_RD, S_AGE_WR, S_CMD,
    S_ENQ_SCAN, S_ENQ_WR, S_PUSH1, S_PUSH2, S_DQR_RD, S_DQR_CHK, S_DQ_INIT,
    S_DQ_RD, S_DQ_CHK, S_REMOVE, S_LR_RD, S_LR_EMIT, S_LW_INIT, S_LW_RD,
    S_LW_EMIT, S_SEL_INIT, S_SEL_RD, S_SEL_CHK, S_SEL_REQ, S_RQ_RD, S_RQ_WR,
    S_START, S_ST_RD, S_ST_WR, S_REPORT
  } state_e;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [PriW-1:0]   bpri_q, bpri_d;
  logic [IdW-1:0]    owner_q, owner_d, target_q, target_d;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d, rs_q, rs_d;
  logic [CW-1:0]     count_q, count_d, i_q, i_d;
  logic              rv_q, rv_d;
  logic [IdW-1:0]    idc_q, idc_d, newid_q, newid_d, rjob_q, rjob_d;
  logic [WaitW-1:0]  aging_q, aging_d;
  logic [PriW-1:0]   cap_q, cap_d, best_q, best_d;
  logic [MAX_JOBS-1:0] valid_q, valid_d;
  logic [IW-1:0]     p_q, p_d, prev_q, prev_d, scan_q, scan_d, push_q, push_d;
  logic [IW-1:0]     sel_q, sel_d, sel_prev_q, sel_prev_d, sel_next_q, sel_next_d;
  logic              sel_first_q, sel_first_d, sw_q, sw_d, out_v_q, out_v_d;
  logic [1:0]        status_q, status_d;
  rec_t              rec_q, rec_d;

  logic              d_we, l_we, use_rs, out_free, take;
  logic [IW-1:0]     d_waddr, l_waddr, l_wdata, raddr, lrd;
  slot_t             d_wdata, rd, aged;
  logic [SW-1:0]     rd_raw;
  logic [IdW-1:0]    id_next;

  apjs_ram #(.Width(SW), .Depth(MAX_JOBS)) u_slot_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(raddr), .rdata_o(rd_raw)
  );

  apjs_ram #(.Width(IW), .Depth(MAX_JOBS)) u_link_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(raddr), .rdata_o(lrd)
  );

  assign rd       = slot_t'(rd_raw);
  assign out_free = !out_v_q || !out_stall_i;
  assign take     = (i_q == '0) || (rd.cur_pri > best_q);
  assign id_next  = (idc_q == {IdW{1'b1}}) ? IdW'(1) : idc_q + IdW'(1);

  always_comb begin
    case (state_q)
      S_RUN_RD, S_RUN_WR, S_DQR_RD, S_DQR_CHK, S_LR_RD, S_LR_EMIT,
      S_RQ_RD, S_RQ_WR, S_ST_RD, S_ST_WR: use_rs = 1'b1;
      default:                            use_rs = 1'b0;
    endcase
  end
  assign raddr = use_rs ? rs_q : p_q;

  // Aging of one waiting job: saturating wait count, then a level up at the threshold while below the cap.
  always_comb begin
    aged = rd;
    if (rd.wait_cnt != {WaitW{1'b1}}) begin
      aged.wait_cnt = rd.wait_cnt + WaitW'(1);
    end
    if (aged.wait_cnt >= aging_q && rd.cur_pri < cap_q) begin
      aged.cur_pri  = rd.cur_pri + PriW'(1);
      aged.wait_cnt = '0;
    end
  end

  always_comb begin
    state_d = state_q;   ret_d = ret_q;     cmd_d = cmd_q;     bpri_d = bpri_q;
    owner_d = owner_q;   target_d = target_q; head_d = head_q; tail_d = tail_q;
    rs_d = rs_q;         count_d = count_q; i_d = i_q;         rv_d = rv_q;
    idc_d = idc_q;       newid_d = newid_q; rjob_d = rjob_q;   aging_d = aging_q;
    cap_d = cap_q;       best_d = best_q;   valid_d = valid_q; p_d = p_q;
    prev_d = prev_q;     scan_d = scan_q;   push_d = push_q;   sel_d = sel_q;
    sel_prev_d = sel_prev_q; sel_next_d = sel_next_q; sel_first_d = sel_first_q;
    sw_d = sw_q;         status_d = status_q; rec_d = rec_q;
    out_v_d = out_v_q && out_stall_i;
    d_we = 1'b0; d_waddr = raddr; d_wdata = rd;
    l_we = 1'b0; l_waddr = '0;    l_wdata = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgAging) begin
        aging_d = cfg_data_i;
      end else begin
        cap_d = cfg_data_i[PriW-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i; bpri_d = base_priority_i; owner_d = owner_id_i;
          target_d = target_job_i; newid_d = '0; status_d = StatOk; sw_d = 1'b0;
          if (running_finished_i && rv_q) begin
            valid_d[rs_q] = 1'b0;
            rv_d = 1'b0;
            state_d = S_AGE_INIT;
          end else if (rv_q) begin
            state_d = S_RUN_RD;
          end else begin
            state_d = S_AGE_INIT;
          end
        end
      end
      S_RUN_RD: state_d = S_RUN_WR;
      S_RUN_WR: begin
        d_we = 1'b1;
        if (rd.run_cnt != {RunW{1'b1}}) begin
          d_wdata.run_cnt = rd.run_cnt + RunW'(1);
        end
        state_d = S_AGE_INIT;
      end
      S_AGE_INIT: begin
        p_d = head_q; i_d = '0;
        state_d = (count_q == '0) ? S_CMD : S_AGE_RD;
      end
      S_AGE_RD: state_d = S_AGE_WR;
      S_AGE_WR: begin
        d_we = 1'b1; d_wdata = aged;
        p_d = lrd; i_d = i_q + CW'(1);
        state_d = (i_q + CW'(1) == count_q) ? S_CMD : S_AGE_RD;
      end
      S_CMD: begin
        case (cmd_q)
          CmdEnqueue: begin
            scan_d = '0; state_d = S_ENQ_SCAN;
          end
          CmdDequeue: state_d = rv_q ? S_DQR_RD : S_DQ_INIT;
          CmdList:    state_d = rv_q ? S_LR_RD : S_LW_INIT;
          default:    state_d = S_SEL_INIT;
        endcase
      end
      S_ENQ_SCAN: begin
        if (!valid_q[scan_q]) begin
          state_d = S_ENQ_WR;
        end else if (scan_q == IW'(MAX_JOBS - 1)) begin
          status_d = StatFull; state_d = S_SEL_INIT;
        end else begin
          scan_d = scan_q + IW'(1);
        end
      end
      S_ENQ_WR: begin
        idc_d = id_next; newid_d = id_next; valid_d[scan_q] = 1'b1;
        d_we = 1'b1; d_waddr = scan_q;
        d_wdata = '{job_id: id_next, owner: owner_q, base_pri: bpri_q,
                    cur_pri: bpri_q, wait_cnt: '0, run_cnt: '0};
        push_d = scan_q; ret_d = S_SEL_INIT; state_d = S_PUSH1;
      end
      S_PUSH1: begin
        l_we = 1'b1; l_waddr = push_q; l_wdata = '0;
        if (count_q == '0) begin
          head_d = push_q; tail_d = push_q; count_d = count_q + CW'(1);
          state_d = ret_q;
        end else begin
          state_d = S_PUSH2;
        end
      end
      S_PUSH2: begin
        l_we = 1'b1; l_waddr = tail_q; l_wdata = push_q;
        tail_d = push_q; count_d = count_q + CW'(1);
        state_d = ret_q;
      end
      S_DQR_RD: state_d = S_DQR_CHK;
      S_DQR_CHK: begin
        if (rd.job_id == target_q) begin
          valid_d[rs_q] = 1'b0; rv_d = 1'b0; state_d = S_SEL_INIT;
        end else begin
          state_d = S_DQ_INIT;
        end
      end
      S_DQ_INIT: begin
        p_d = head_q; i_d = '0; prev_d = '0;
        if (count_q == '0) begin
          status_d = StatNotFound; state_d = S_SEL_INIT;
        end else begin
          state_d = S_DQ_RD;
        end
      end
      S_DQ_RD: state_d = S_DQ_CHK;
      S_DQ_CHK: begin
        if (rd.job_id == target_q) begin
          valid_d[p_q] = 1'b0;
          sel_d = p_q; sel_prev_d = prev_q; sel_next_d = lrd;
          sel_first_d = (i_q == '0);
          ret_d = S_SEL_INIT; state_d = S_REMOVE;
        end else begin
          prev_d = p_q; p_d = lrd; i_d = i_q + CW'(1);
          if (i_q + CW'(1) == count_q) begin
            status_d = StatNotFound; state_d = S_SEL_INIT;
          end else begin
            state_d = S_DQ_RD;
          end
        end
      end
      S_REMOVE: begin
        if (sel_first_q) begin
          head_d = sel_next_q;
        end else begin
          l_we = 1'b1; l_waddr = sel_prev_q; l_wdata = sel_next_q;
        end
        if (sel_q == tail_q) begin
          tail_d = sel_prev_q;
        end
        count_d = count_q - CW'(1);
        if (count_q == CW'(1)) begin
          head_d = '0; tail_d = '0;
        end
        state_d = ret_q;
      end
      S_LR_RD: state_d = S_LR_EMIT;
      S_LR_EMIT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          rec_d = '{kind: 1'b1, job_number: rd.job_id, job_owner: rd.owner,
                    run_ticks: rd.run_cnt, wait_ticks: rd.wait_cnt,
                    job_priority: rd.cur_pri, is_running: 1'b1, running_job: '0,
                    switched: 1'b0, status: StatOk, last: 1'b0};
          state_d = S_LW_INIT;
        end
      end
      S_LW_INIT: begin
        p_d = head_q; i_d = '0;
        state_d = (count_q == '0) ? S_SEL_INIT : S_LW_RD;
      end
      S_LW_RD: state_d = S_LW_EMIT;
      S_LW_EMIT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          rec_d = '{kind: 1'b1, job_number: rd.job_id, job_owner: rd.owner,
                    run_ticks: rd.run_cnt, wait_ticks: rd.wait_cnt,
                    job_priority: rd.cur_pri, is_running: 1'b0, running_job: '0,
                    switched: 1'b0, status: StatOk, last: 1'b0};
          p_d = lrd; i_d = i_q + CW'(1);
          state_d = (i_q + CW'(1) == count_q) ? S_SEL_INIT : S_LW_RD;
        end
      end
      S_SEL_INIT: begin
        p_d = head_q; i_d = '0; prev_d = '0;
        if (count_q == '0) begin
          rjob_d = '0;
          state_d = rv_q ? S_ST_RD : S_REPORT;
        end else begin
          state_d = S_SEL_RD;
        end
      end
      S_SEL_RD: state_d = S_SEL_CHK;
      S_SEL_CHK: begin
        // Strictly greater keeps the job nearest the head on a tie.
        if (take) begin
          best_d = rd.cur_pri; sel_d = p_q; sel_prev_d = prev_q;
          sel_next_d = lrd; sel_first_d = (i_q == '0);
        end
        prev_d = p_q; p_d = lrd; i_d = i_q + CW'(1);
        if (i_q + CW'(1) == count_q) begin
          ret_d = S_SEL_REQ; state_d = S_REMOVE;
        end else begin
          state_d = S_SEL_RD;
        end
      end
      S_SEL_REQ: state_d = rv_q ? S_RQ_RD : S_START;
      S_RQ_RD:   state_d = S_RQ_WR;
      S_RQ_WR: begin
        d_we = 1'b1;
        d_wdata.cur_pri = rd.base_pri; d_wdata.wait_cnt = '0;
        push_d = rs_q; ret_d = S_START; state_d = S_PUSH1;
      end
      S_START: begin
        rs_d = sel_q; rv_d = 1'b1; sw_d = 1'b1; state_d = S_ST_RD;
      end
      S_ST_RD: state_d = S_ST_WR;
      S_ST_WR: begin
        // Also serves the no-switch case to fetch the running job's id.
        if (sw_q) begin
          d_we = 1'b1; d_wdata.wait_cnt = '0;
        end
        rjob_d = rd.job_id; state_d = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          rec_d = '{kind: 1'b0, job_number: newid_q, job_owner: '0, run_ticks: '0,
                    wait_ticks: '0, job_priority: '0, is_running: 1'b0,
                    running_job: rjob_q, switched: sw_q, status: status_q,
                    last: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE;
      head_q <= '0; tail_q <= '0; count_q <= '0; rs_q <= '0; rv_q <= 1'b0;
      idc_q <= '0; aging_q <= WaitW'(5); cap_q <= PriW'(3);
      valid_q <= '0; out_v_q <= 1'b0; rec_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      head_q <= head_d; tail_q <= tail_d; count_q <= count_d; rs_q <= rs_d;
      rv_q <= rv_d; idc_q <= idc_d; aging_q <= aging_d; cap_q <= cap_d;
      valid_q <= valid_d; out_v_q <= out_v_d; rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; bpri_q <= bpri_d; owner_q <= owner_d; target_q <= target_d;
    i_q <= i_d; newid_q <= newid_d; rjob_q <= rjob_d; best_q <= best_d;
    p_q <= p_d; prev_q <= prev_d; scan_q <= scan_d; push_q <= push_d;
    sel_q <= sel_d; sel_prev_q <= sel_prev_d; sel_next_q <= sel_next_d;
    sel_first_q <= sel_first_d; sw_q <= sw_d; status_q <= status_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_v_q;
  assign record_kind_o  = rec_q.kind;
  assign job_number_o   = rec_q.job_number;
  assign job_owner_o    = rec_q.job_owner;
  assign run_ticks_o    = rec_q.run_ticks;
  assign wait_ticks_o   = rec_q.wait_ticks;
  assign job_priority_o = rec_q.job_priority;
  assign is_running_o   = rec_q.is_running;
  assign running_job_o  = rec_q.running_job;
  assign switched_o     = rec_q.switched;
  assign status_o       = rec_q.status;
  assign last_o         = rec_q.last;

endmodule

// File: design/apjs_checker.sv
// Port-level checker for the aging priority job scheduler, bound to the top level.
// Depends on aging_priority_job_scheduler and apjs_pkg.
module apjs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        record_kind_o,
  input logic [15:0] job_number_o,
  input logic        is_running_o,
  input logic [15:0] running_job_o,
  input logic [1:0]  status_o,
  input logic        last_o
);
  import apjs_pkg::*;

  // Accepting a tick leaves the idle state, so the input closes right after a word is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a tick was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(job_number_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o != record_kind_o))
    else $error("listing word flagged last or report not flagged last");

  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !is_running_o && status_o != 2'd3)
    else $error("malformed tick report");

  a_list_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o |-> status_o == StatOk && running_job_o == '0)
    else $error("listing word carries report fields");

endmodule

bind aging_priority_job_scheduler apjs_checker u_apjs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .record_kind_o, .job_number_o, .is_running_o, .running_job_o, .status_o, .last_o
);

// File: test/tb.sv
// Testbench for the aging priority job scheduler: directed table, then random ticks.
// Depends on apjs_pkg; results are checked word by word against a predictor kept here.
`timescale 1ns / 1ps

module tb;
  import apjs_pkg::*;

  localparam int unsigned Slots     = 16;
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned PhaseLen  = 80;
  localparam int unsigned NumPhases = 6;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  bpri;
    logic [15:0] owner;
    logic [15:0] target;
    logic        fin;
  } tick_t;

  typedef struct {
    tick_t t;
    bit    typed;
    rec_t  report;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [3:0]  base_priority_i;
  logic [15:0] owner_id_i;
  logic [15:0] target_job_i;
  logic        running_finished_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        record_kind_o;
  logic [15:0] job_number_o;
  logic [15:0] job_owner_o;
  logic [31:0] run_ticks_o;
  logic [7:0]  wait_ticks_o;
  logic [3:0]  job_priority_o;
  logic        is_running_o;
  logic [15:0] running_job_o;
  logic        switched_o;
  logic [1:0]  status_o;
  logic        last_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;

  aging_priority_job_scheduler dut (.*);

  // Scheduler state as the predictor sees it.
  logic        sl_valid [Slots];
  logic [15:0] sl_id    [Slots];
  logic [15:0] sl_owner [Slots];
  logic [3:0]  sl_base  [Slots];
  logic [3:0]  sl_pri   [Slots];
  logic [7:0]  sl_wait  [Slots];
  logic [31:0] sl_run   [Slots];
  logic [3:0]  sl_next  [Slots];
  logic [3:0]  q_head, q_tail, cur_slot;
  int          q_len;
  bit          cur_ok;
  logic [15:0] id_seq;
  logic [7:0]  age_limit;
  logic [3:0]  pri_cap;

  rec_t        expected_words[$];
  int          errors;
  int unsigned cycles;
  bit          idle_on;
  row_t        rows[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void enqueue_slot(logic [3:0] s);
    sl_next[s] = '0;
    if (q_len == 0) q_head = s;
    else sl_next[q_tail] = s;
    q_tail = s;
    q_len++;
  endfunction

  function automatic void unlink_slot(logic [3:0] s);
    logic [3:0] cur, prev;
    cur  = q_head;
    prev = '0;
    for (int i = 0; i < q_len; i++) begin
      if (cur == s) begin
        if (i == 0) q_head = sl_next[cur];
        else sl_next[prev] = sl_next[cur];
        if (cur == q_tail) q_tail = prev;
        q_len--;
        if (q_len == 0) begin
          q_head = '0;
          q_tail = '0;
        end
        return;
      end
      prev = cur;
      cur  = sl_next[cur];
    end
  endfunction

  function automatic rec_t listing_word(logic [3:0] s, logic running);
    rec_t r;
    r              = '0;
    r.kind         = 1'b1;
    r.job_number   = sl_id[s];
    r.job_owner    = sl_owner[s];
    r.run_ticks    = sl_run[s];
    r.wait_ticks   = sl_wait[s];
    r.job_priority = sl_pri[s];
    r.is_running   = running;
    return r;
  endfunction

  // Advances the predicted scheduler by one tick and queues the words it emits.
  function automatic void schedule_tick(tick_t t);
    rec_t        r;
    logic [3:0]  p, s, pick;
    logic [15:0] new_id;
    logic [1:0]  stat;
    logic        sw, hit;
    int          best;
    new_id = '0;
    stat   = StatOk;
    sw     = 1'b0;
    if (t.fin && cur_ok) begin
      sl_valid[cur_slot] = 1'b0;
      cur_ok = 1'b0;
    end
    if (cur_ok && sl_run[cur_slot] != 32'hFFFF_FFFF) sl_run[cur_slot]++;
    p = q_head;
    for (int i = 0; i < q_len; i++) begin
      if (sl_wait[p] != 8'hFF) sl_wait[p]++;
      if (sl_wait[p] >= age_limit && sl_pri[p] < pri_cap) begin
        sl_pri[p]++;
        sl_wait[p] = '0;
      end
      p = sl_next[p];
    end
    case (t.cmd)
      CmdEnqueue: begin
        hit = 1'b0;
        s   = '0;
        for (int i = Slots - 1; i >= 0; i--) begin
          if (!sl_valid[i]) begin
            s   = 4'(i);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          stat = StatFull;
        end else begin
          id_seq = id_seq + 16'd1;
          if (id_seq == '0) id_seq = 16'd1;
          sl_valid[s] = 1'b1;
          sl_id[s]    = id_seq;
          sl_owner[s] = t.owner;
          sl_base[s]  = t.bpri;
          sl_pri[s]   = t.bpri;
          sl_wait[s]  = '0;
          sl_run[s]   = '0;
          enqueue_slot(s);
          new_id = id_seq;
        end
      end
      CmdDequeue: begin
        if (cur_ok && sl_id[cur_slot] == t.target) begin
          sl_valid[cur_slot] = 1'b0;
          cur_ok = 1'b0;
        end else begin
          hit = 1'b0;
          p   = q_head;
          for (int i = 0; i < q_len && !hit; i++) begin
            if (sl_id[p] == t.target) hit = 1'b1;
            else p = sl_next[p];
          end
          if (hit) begin
            unlink_slot(p);
            sl_valid[p] = 1'b0;
          end else begin
            stat = StatNotFound;
          end
        end
      end
      CmdList: begin
        if (cur_ok) expected_words.push_back(listing_word(cur_slot, 1'b1));
        p = q_head;
        for (int i = 0; i < q_len; i++) begin
          expected_words.push_back(listing_word(p, 1'b0));
          p = sl_next[p];
        end
      end
      default: ;
    endcase
    if (q_len > 0) begin
      pick = q_head;
      best = -1;
      p    = q_head;
      for (int i = 0; i < q_len; i++) begin
        if (int'(sl_pri[p]) > best) begin
          best = int'(sl_pri[p]);
          pick = p;
        end
        p = sl_next[p];
      end
      unlink_slot(pick);
      if (cur_ok) begin
        sl_pri[cur_slot]  = sl_base[cur_slot];
        sl_wait[cur_slot] = '0;
        enqueue_slot(cur_slot);
      end
      cur_slot      = pick;
      cur_ok        = 1'b1;
      sl_wait[pick] = '0;
      sw            = 1'b1;
    end
    r             = '0;
    r.job_number  = new_id;
    r.running_job = cur_ok ? sl_id[cur_slot] : '0;
    r.switched    = sw;
    r.status      = stat;
    r.last        = 1'b1;
    expected_words.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Output monitor: every accepted word is matched against the oldest expectation.
  always @(posedge clk_i) begin
    rec_t w;
    cycles++;
    if (cycles > CycleCap) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 32'(job_number_o), '0);
      end else begin
        w = expected_words.pop_front();
        if (record_kind_o !== w.kind)
          report_mismatch("record_kind", 32'(record_kind_o), 32'(w.kind));
        if (job_number_o !== w.job_number)
          report_mismatch("job_number", 32'(job_number_o), 32'(w.job_number));
        if (job_owner_o !== w.job_owner)
          report_mismatch("job_owner", 32'(job_owner_o), 32'(w.job_owner));
        if (run_ticks_o !== w.run_ticks) report_mismatch("run_ticks", run_ticks_o, w.run_ticks);
        if (wait_ticks_o !== w.wait_ticks)
          report_mismatch("wait_ticks", 32'(wait_ticks_o), 32'(w.wait_ticks));
        if (job_priority_o !== w.job_priority)
          report_mismatch("job_priority", 32'(job_priority_o), 32'(w.job_priority));
        if (is_running_o !== w.is_running)
          report_mismatch("is_running", 32'(is_running_o), 32'(w.is_running));
        if (running_job_o !== w.running_job)
          report_mismatch("running_job", 32'(running_job_o), 32'(w.running_job));
        if (switched_o !== w.switched)
          report_mismatch("switched", 32'(switched_o), 32'(w.switched));
        if (status_o !== w.status) report_mismatch("status", 32'(status_o), 32'(w.status));
        if (last_o !== w.last) report_mismatch("last", 32'(last_o), 32'(w.last));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 13);
  end

  task automatic send_tick(tick_t t, bit typed, rec_t report);
    if (idle_on && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    cmd_i              <= t.cmd;
    base_priority_i    <= t.bpri;
    owner_id_i         <= t.owner;
    target_job_i       <= t.target;
    running_finished_i <= t.fin;
    in_valid_i         <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    schedule_tick(t);
    if (typed) begin
      void'(expected_words.pop_back());
      expected_words.push_back(report);
    end
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(logic [7:0] aging, logic [3:0] cap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgAging;
    cfg_data_i <= aging;
    @(posedge clk_i);
    cfg_idx_i  <= CfgCap;
    cfg_data_i <= {4'($urandom), cap};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    age_limit = aging;
    pri_cap   = cap;
  endtask

  function automatic tick_t make_tick(logic [1:0] c, logic [3:0] bp, logic [15:0] ow,
                                      logic [15:0] tg, logic f);
    tick_t t;
    t.cmd    = c;
    t.bpri   = bp;
    t.owner  = ow;
    t.target = tg;
    t.fin    = f;
    return t;
  endfunction

  function automatic void add_row(tick_t t, bit typed, rec_t report);
    row_t r;
    r.t      = t;
    r.typed  = typed;
    r.report = report;
    rows.push_back(r);
  endfunction

  // Three in four dequeue targets are taken from a random slot when it is live, so removals actually happen.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned roll;
    logic [3:0]  s;
    roll = $urandom_range(99);
    t = make_tick(CmdTick, 4'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(99) < 15);
    if (roll < 35) t.cmd = CmdEnqueue;
    else if (roll < 57) t.cmd = CmdDequeue;
    else if (roll < 70) t.cmd = CmdList;
    if (t.cmd == CmdDequeue && $urandom_range(99) < 75) begin
      s = 4'($urandom);
      if (sl_valid[s]) t.target = sl_id[s];
    end
    return t;
  endfunction

  initial begin
    rec_t  rep;
    rec_t  none;
    logic [7:0] ages [NumPhases];
    logic [3:0] caps [NumPhases];
    errors  = 0;
    cycles  = 0;
    idle_on = 1'b0;
    none    = '0;
    for (int i = 0; i < Slots; i++) begin
      sl_valid[i] = 1'b0; sl_id[i] = '0; sl_owner[i] = '0; sl_base[i] = '0;
      sl_pri[i] = '0; sl_wait[i] = '0; sl_run[i] = '0; sl_next[i] = '0;
    end
    q_head = '0; q_tail = '0; q_len = 0; cur_slot = '0; cur_ok = 1'b0; id_seq = '0;
    age_limit = 8'd5;
    pri_cap   = 4'd3;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    cmd_i              <= CmdTick;
    base_priority_i    <= '0;
    owner_id_i         <= '0;
    target_job_i       <= '0;
    running_finished_i <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgAging;
    cfg_data_i         <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_config(8'd5, 4'd3);

    // Idle tick, first enqueue, and a dequeue miss have reports known by inspection.
    rep = '0; rep.last = 1'b1;
    add_row(make_tick(CmdTick, '0, '0, '0, 1'b1), 1'b1, rep);
    rep.job_number = 16'd1; rep.running_job = 16'd1; rep.switched = 1'b1;
    add_row(make_tick(CmdEnqueue, 4'hF, 16'hFFFF, '0, 1'b0), 1'b1, rep);
    rep = '0; rep.last = 1'b1; rep.running_job = 16'd1; rep.status = StatNotFound;
    add_row(make_tick(CmdDequeue, 4'hF, 16'hFFFF, 16'hFFFF, 1'b0), 1'b1, rep);
    add_row(make_tick(CmdList, '0, '0, '0, 1'b0), 1'b0, none);
    // Fill the store, then one more enqueue is dropped as full.
    for (int i = 0; i < 16; i++)
      add_row(make_tick(CmdEnqueue, 4'(i), 16'(i * 4099), '0, 1'b0), 1'b0, none);
    add_row(make_tick(CmdList, '0, '0, '0, 1'b0), 1'b0, none);
    add_row(make_tick(CmdDequeue, '0, '0, 16'd2, 1'b0), 1'b0, none);
    add_row(make_tick(CmdDequeue, '0, '0, 16'd17, 1'b0), 1'b0, none);
    add_row(make_tick(CmdTick, '0, '0, '0, 1'b1), 1'b0, none);
    add_row(make_tick(CmdList, 4'hF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, none);
    foreach (rows[i]) send_tick(rows[i].t, rows[i].typed, rows[i].report);
    drain_words();

    ages = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom), 8'd5};
    caps = '{4'd0, 4'd15, 4'd15, 4'd7, 4'($urandom), 4'd3};
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_config(ages[ph], caps[ph]);
      idle_on = (ph != 2);
      for (int n = 0; n < PhaseLen; n++) send_tick(random_tick(), 1'b0, none);
      drain_words();
    end
    idle_on = 1'b0;
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
